/* rtl/core/hht_pkg.sv */
// ----------------------------------------------------------------------------
// hht_pkg
// Shared types and constants of the HTTP header tokenizer: character codes,
// token kinds, parse phases, controller states and control structs.
// ----------------------------------------------------------------------------
package hht_pkg;

  localparam int unsigned DEFAULT_PENDING_DEPTH = 16;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef enum logic [2:0] {
    TK_KEY_BYTE    = 3'd0,
    TK_KEY_END     = 3'd1,
    TK_VALUE_BYTE  = 3'd2,
    TK_VALUE_END   = 3'd3,
    TK_HDR_DONE    = 3'd4,
    TK_BAD_KEY     = 3'd5,
    TK_BAD_HDR_END = 3'd6,
    TK_WS_OVERFLOW = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    PH_KEY      = 3'd0,
    PH_KEY_CR   = 3'd1,
    PH_VALUE    = 3'd2,
    PH_VAL_CR   = 3'd3,
    PH_VAL_CRLF = 3'd4,
    PH_DONE     = 3'd5,
    PH_FAILED   = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_EVAL,
    CS_HOLD,
    CS_PRE,
    CS_FL_RD,
    CS_FL_OUT,
    CS_FIN
  } ctrl_e;

  typedef enum logic [1:0] {
    OS_PRE,
    OS_FLUSH,
    OS_FIN
  } out_sel_e;

  // Everything one byte does, decided in one evaluation.
  typedef struct packed {
    logic       pre_end;    // value end goes out before anything else
    logic       clr_base;   // holds start over at an empty buffer
    logic [1:0] n_hold;
    logic [7:0] hold0;
    logic [7:0] hold1;
    logic [7:0] hold2;
    logic       flush;
    kind_e      flush_kind;
    logic       fin;
    kind_e      fin_kind;
    logic [7:0] fin_byte;
    phase_e     nx_phase;
    logic       nx_fs;
    logic       cnt_clear;
  } plan_t;

  typedef struct packed {
    logic     load_in;
    logic     eval;
    logic     idx_clr;
    logic     idx_inc;
    logic     ram_we;
    logic     out_load;
    out_sel_e out_sel;
    logic     out_last;
  } cmd_t;

  typedef struct packed {
    logic has_holds;
    logic hold_last;
    logic pre_end;
    logic flush_go;
    logic flush_last;
    logic fin;
    logic out_free;
  } sts_t;

endpackage

/* rtl/core/hht_ram.sv */
// ----------------------------------------------------------------------------
// hht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hht_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/hht_dp.sv */
// ----------------------------------------------------------------------------
// hht_dp
// Datapath: input register, parse state, byte decode, pending whitespace
// buffer with its index, and the output register.
// ----------------------------------------------------------------------------
module hht_dp import hht_pkg::*; #(
  parameter int unsigned PENDING_DEPTH = DEFAULT_PENDING_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] data_byte_i,
  input  logic       restart_i,
  input  logic       out_stall_i,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  output logic [2:0] token_kind_o,
  output logic [7:0] token_byte_o,
  output logic       last_o,
  output logic       out_valid_o
);

  localparam int unsigned CNT_W  = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned SUM_W  = $clog2(PENDING_DEPTH + 4);
  localparam int unsigned ADDR_W = $clog2(PENDING_DEPTH);

  function automatic plan_t key_plan(input logic [7:0] b, input logic fs);
    plan_t p;
    p          = '0;
    p.nx_phase = PH_KEY;
    p.nx_fs    = fs;
    if (b == CH_COLON) begin
      p.cnt_clear = 1'b1;
      p.nx_fs     = 1'b0;
      p.nx_phase  = PH_VALUE;
      p.fin       = 1'b1;
      p.fin_kind  = TK_KEY_END;
    end else if ((b == CH_CR && fs) || b == CH_LF) begin
      p.cnt_clear = 1'b1;
      p.nx_phase  = PH_FAILED;
      p.fin       = 1'b1;
      p.fin_kind  = TK_BAD_KEY;
    end else if (b == CH_CR) begin
      p.nx_phase = PH_KEY_CR;
    end else if (!(b == CH_SP && !fs)) begin
      p.nx_fs = 1'b1;
      if (b == CH_SP || b == CH_TAB) begin
        p.n_hold = 2'd1;
        p.hold0  = b;
      end else begin
        p.flush      = 1'b1;
        p.flush_kind = TK_KEY_BYTE;
        p.fin        = 1'b1;
        p.fin_kind   = TK_KEY_BYTE;
        p.fin_byte   = b;
      end
    end
    return p;
  endfunction

  function automatic plan_t value_plan(input logic [7:0] b, input logic fs);
    plan_t p;
    p          = '0;
    p.nx_phase = PH_VALUE;
    p.nx_fs    = fs;
    if (b == CH_CR) begin
      p.nx_phase = PH_VAL_CR;
    end else if (!(b == CH_SP && !fs)) begin
      p.nx_fs = 1'b1;
      if (b == CH_SP || b == CH_TAB || b == CH_LF) begin
        p.n_hold = 2'd1;
        p.hold0  = b;
      end else begin
        p.flush      = 1'b1;
        p.flush_kind = TK_VALUE_BYTE;
        p.fin        = 1'b1;
        p.fin_kind   = TK_VALUE_BYTE;
        p.fin_byte   = b;
      end
    end
    return p;
  endfunction

  logic [7:0]        byte_q;
  logic              restart_q;
  phase_e            phase_q;
  logic              fs_q;
  logic [CNT_W-1:0]  cnt_q;
  plan_t             plan_q;
  logic [SUM_W-1:0]  base_q;
  logic [CNT_W-1:0]  flush_n_q;
  logic [CNT_W-1:0]  idx_q;
  logic              out_valid_q;
  logic [2:0]        kind_q;
  logic [7:0]        tbyte_q;
  logic              last_q;

  phase_e            ph_eff;
  logic              fs_eff;
  logic [CNT_W-1:0]  cnt_eff;
  plan_t             plan;
  plan_t             plan_d;
  logic [SUM_W-1:0]  base;
  logic [SUM_W-1:0]  sum;
  logic              ovf;
  logic [SUM_W-1:0]  waddr_full;
  logic [7:0]        wdata;
  logic [7:0]        rdata;

  // Restart drops the parse state before the byte is looked at.
  assign ph_eff  = restart_q ? PH_KEY : phase_q;
  assign fs_eff  = restart_q ? 1'b0 : fs_q;
  assign cnt_eff = restart_q ? '0 : cnt_q;

  always_comb begin
    plan          = '0;
    plan.nx_phase = ph_eff;
    plan.nx_fs    = fs_eff;
    case (ph_eff)
      PH_KEY: begin
        plan = key_plan(byte_q, fs_eff);
      end
      PH_KEY_CR: begin
        plan.fin       = 1'b1;
        plan.cnt_clear = 1'b1;
        if (byte_q == CH_LF) begin
          plan.nx_phase = PH_DONE;
          plan.fin_kind = TK_HDR_DONE;
        end else begin
          plan.nx_phase = PH_FAILED;
          plan.fin_kind = TK_BAD_HDR_END;
        end
      end
      PH_VALUE: begin
        plan = value_plan(byte_q, fs_eff);
      end
      PH_VAL_CR: begin
        if (byte_q == CH_LF) begin
          plan.nx_phase = PH_VAL_CRLF;
        end else begin
          // The lone CR becomes value whitespace ahead of this byte.
          plan        = value_plan(byte_q, 1'b1);
          plan.hold1  = plan.hold0;
          plan.hold0  = CH_CR;
          plan.n_hold = plan.n_hold + 2'd1;
        end
      end
      PH_VAL_CRLF: begin
        if (byte_q == CH_SP || byte_q == CH_TAB) begin
          // Folded line: keep CR LF and the fold byte as whitespace.
          plan.nx_phase = PH_VALUE;
          plan.nx_fs    = 1'b1;
          plan.n_hold   = 2'd3;
          plan.hold0    = CH_CR;
          plan.hold1    = CH_LF;
          plan.hold2    = byte_q;
        end else begin
          plan          = key_plan(byte_q, 1'b0);
          plan.pre_end  = 1'b1;
          plan.clr_base = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign base = plan.clr_base ? '0 : SUM_W'(cnt_eff);
  assign sum  = base + SUM_W'(plan.n_hold);
  assign ovf  = sum > SUM_W'(PENDING_DEPTH);

  always_comb begin
    plan_d = plan;
    if (ovf) begin
      plan_d           = '0;
      plan_d.nx_phase  = PH_FAILED;
      plan_d.nx_fs     = plan.nx_fs;
      plan_d.cnt_clear = 1'b1;
      plan_d.fin       = 1'b1;
      plan_d.fin_kind  = TK_WS_OVERFLOW;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      byte_q    <= data_byte_i;
      restart_q <= restart_i;
    end
    if (cmd_i.eval) begin
      plan_q    <= plan_d;
      base_q    <= base;
      flush_n_q <= sum[CNT_W-1:0];
    end
  end

  // A drain empties the buffer, so its count restarts from zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_KEY;
      fs_q    <= 1'b0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      if (cmd_i.eval) begin
        phase_q <= plan_d.nx_phase;
        fs_q    <= plan_d.nx_fs;
        cnt_q   <= (plan_d.cnt_clear || plan_d.flush) ? '0 : sum[CNT_W-1:0];
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + CNT_W'(1);
      end
    end
  end

  // Pending whitespace buffer: appended at base + idx, drained from 0.
  assign waddr_full = base_q + SUM_W'(idx_q);

  always_comb begin
    case (idx_q[1:0])
      2'd0:    wdata = plan_q.hold0;
      2'd1:    wdata = plan_q.hold1;
      default: wdata = plan_q.hold2;
    endcase
  end

  hht_ram #(
    .WIDTH (8),
    .DEPTH (PENDING_DEPTH)
  ) u_pend (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .waddr_i (waddr_full[ADDR_W-1:0]),
    .wdata_i (wdata),
    .raddr_i (idx_q[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      last_q <= cmd_i.out_last;
      case (cmd_i.out_sel)
        OS_PRE: begin
          kind_q  <= TK_VALUE_END;
          tbyte_q <= 8'h00;
        end
        OS_FLUSH: begin
          kind_q  <= plan_q.flush_kind;
          tbyte_q <= rdata;
        end
        default: begin
          kind_q  <= plan_q.fin_kind;
          tbyte_q <= plan_q.fin_byte;
        end
      endcase
    end
  end

  assign sts_o.has_holds  = plan_q.n_hold != 2'd0;
  assign sts_o.hold_last  = idx_q == CNT_W'(plan_q.n_hold - 2'd1);
  assign sts_o.pre_end    = plan_q.pre_end;
  assign sts_o.flush_go   = plan_q.flush && (flush_n_q != '0);
  assign sts_o.flush_last = idx_q == (flush_n_q - CNT_W'(1));
  assign sts_o.fin        = plan_q.fin;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign token_kind_o = kind_q;
  assign token_byte_o = tbyte_q;
  assign last_o       = last_q;
  assign out_valid_o  = out_valid_q;

endmodule

/* rtl/core/hht_ctrl.sv */
// ----------------------------------------------------------------------------
// hht_ctrl
// Controller: accepts one byte, has it evaluated, then sequences the
// whitespace writes, value end, buffer drain and final token.
// ----------------------------------------------------------------------------
module hht_ctrl import hht_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_e state_q;
  ctrl_e state_d;
  ctrl_e after_flush;
  ctrl_e after_pre;
  ctrl_e after_hold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign after_flush = sts_i.fin ? CS_FIN : CS_IDLE;
  assign after_pre   = sts_i.flush_go ? CS_FL_RD : after_flush;
  assign after_hold  = sts_i.pre_end ? CS_PRE : after_pre;

  assign in_stall_o = state_q != CS_IDLE;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.out_sel = OS_FIN;
    case (state_q)
      CS_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = CS_EVAL;
        end
      end
      CS_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = CS_HOLD;
      end
      CS_HOLD: begin
        if (!sts_i.has_holds) begin
          state_d = after_hold;
        end else begin
          cmd_o.ram_we = 1'b1;
          if (sts_i.hold_last) begin
            cmd_o.idx_clr = 1'b1;
            state_d       = after_hold;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      CS_PRE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OS_PRE;
          cmd_o.out_last = !sts_i.flush_go && !sts_i.fin;
          state_d        = after_pre;
        end
      end
      CS_FL_RD: begin
        state_d = CS_FL_OUT;
      end
      CS_FL_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OS_FLUSH;
          cmd_o.out_last = sts_i.flush_last && !sts_i.fin;
          if (sts_i.flush_last) begin
            cmd_o.idx_clr = 1'b1;
            state_d       = after_flush;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = CS_FL_RD;
          end
        end
      end
      CS_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OS_FIN;
          cmd_o.out_last = 1'b1;
          state_d        = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/http_header_tokenizer.sv */
// ----------------------------------------------------------------------------
// http_header_tokenizer
// Splits an HTTP header block, one byte per transfer, into tagged tokens.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: data_byte_i and restart_i, transferred when in_valid_i is
//   high and in_stall_o is low. restart_i clears the parse state before the
//   byte is handled. Output channel: token_kind_o, token_byte_o and last_o,
//   transferred when out_valid_o is high and out_stall_i is low; last_o
//   marks the final token caused by one input byte.
//   One byte is in work at a time. After its transfer a byte is evaluated,
//   each whitespace byte it holds is written to the pending buffer (up to
//   three, on a folded line), and then the value end, the drained buffer
//   bytes and the final token go out as needed; each drained byte passes
//   a read step and then an output step (the RAM has a registered read
//   port). The first token is loaded only after the evaluation and the
//   hold writes; the next byte is taken once the last token is loaded.
//   The output register lets the controller load a token while the previous
//   one is being taken; when out_stall_i holds, the controller waits in
//   place and no token is lost. Reset puts the parser at a key start with an
//   empty buffer; the buffer contents need no clearing.
// ----------------------------------------------------------------------------
module http_header_tokenizer import hht_pkg::*; #(
  parameter int unsigned PENDING_DEPTH = DEFAULT_PENDING_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       restart_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] token_kind_o,
  output logic [7:0] token_byte_o,
  output logic       last_o
);

  // Commands go from the controller to the datapath, status comes back.
  cmd_t cmd;
  sts_t sts;

  hht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath holds the parse phase, the pending whitespace RAM and the
  // output register.
  hht_dp #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .data_byte_i  (data_byte_i),
    .restart_i    (restart_i),
    .out_stall_i  (out_stall_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .token_kind_o (token_kind_o),
    .token_byte_o (token_byte_o),
    .last_o       (last_o),
    .out_valid_o  (out_valid_o)
  );

endmodule
